// ----- design/gsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types and constants for the grouped score pooling block.
// ----------------------------------------------------------------------------
package gsp_pkg;

    // field widths
    localparam int SCORE_W     = 16;
    localparam int VALUE_W     = 28;
    localparam int COUNT_W     = 13;
    localparam int MAX_REGIONS = 4096;
    localparam int POS_W       = $clog2(MAX_REGIONS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = CFG_IDX_W'(1);

    // divider sizing
    localparam int DIV_STEPS  = VALUE_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

    // saturation limits
    localparam logic [COUNT_W-1:0] TALLY_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_SUM  = 2'd0,
        MODE_MAX  = 2'd1,
        MODE_TSUM = 2'd2,
        MODE_TAVG = 2'd3
    } t_pool_mode;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic acc;          // take one score into the group
        logic start_div;    // close group, launch divider
        logic div_step;     // one divider iteration
        logic load_direct;  // close group, write result register now
        logic load_div;     // write divider result into result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;     // current score closes an average group with kept scores
        logic div_last;     // divider is on its last iteration
        logic out_free;     // result register can take a new value this cycle
    } t_dp_status;

endpackage

// ----- design/gsp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_ctrl
// Controller: sequences scoring, group close, division and result load.
// ----------------------------------------------------------------------------
module gsp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_group_end,
    input  logic                i_out_stall,
    input  logic                i_out_valid_q,
    input  gsp_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output gsp_pkg::t_dp_cmd    o_cmd
);

    gsp_pkg::t_state r_state;
    gsp_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsp_pkg::ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        logic accept;
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        accept     = 1'b0;
        unique case (r_state)
            gsp_pkg::ST_ACCUM: begin
                // hold a group end back only while the result register is blocked
                o_in_stall = i_out_valid_q && i_out_stall && i_group_end;
                accept     = i_in_valid && !o_in_stall;
                o_cmd.acc  = accept;
                if (accept && i_group_end) begin
                    if (i_status.need_div) begin
                        o_cmd.start_div = 1'b1;
                        n_state         = gsp_pkg::ST_DIVIDE;
                    end else begin
                        o_cmd.load_direct = 1'b1;
                    end
                end
            end
            gsp_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = gsp_pkg::ST_EMIT;
                end
            end
            gsp_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_div = 1'b1;
                    n_state        = gsp_pkg::ST_ACCUM;
                end
            end
            default: begin
                n_state = gsp_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule

// ----- design/gsp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_datapath
// Datapath: group accumulators, column position, radix-2 divider and
// result register.
// ----------------------------------------------------------------------------
module gsp_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  gsp_pkg::t_dp_cmd                      i_cmd,
    output gsp_pkg::t_dp_status                   o_status,
    input  logic                                  i_cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic signed [gsp_pkg::SCORE_W-1:0]    i_score,
    input  logic                                  i_column_end,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [gsp_pkg::VALUE_W-1:0]    o_pooled_value,
    output logic [gsp_pkg::COUNT_W-1:0]           o_kept_count,
    output logic [gsp_pkg::POS_W-1:0]             o_max_position,
    output logic                                  o_used_fallback
);

    localparam int SW = gsp_pkg::SCORE_W;
    localparam int VW = gsp_pkg::VALUE_W;
    localparam int CW = gsp_pkg::COUNT_W;
    localparam int PW = gsp_pkg::POS_W;

    localparam logic signed [VW-1:0] ACC_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] ACC_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [SW-1:0] BEST_INIT = {1'b1, {(SW-1){1'b0}}};

    // configuration
    gsp_pkg::t_pool_mode    r_pool_mode;
    logic signed [SW-1:0]   r_score_threshold;

    // group state
    logic signed [VW-1:0]   r_kept_sum,   n_kept_sum;
    logic signed [VW-1:0]   r_group_sum,  n_group_sum;
    logic signed [SW-1:0]   r_best_score, n_best_score;
    logic [PW-1:0]          r_best_pos,   n_best_pos;
    logic [CW-1:0]          r_kept_tally, n_kept_tally;
    logic [PW-1:0]          r_col_pos,    n_col_pos;
    logic                   r_group_open;

    // divider
    logic [VW-1:0]                  r_quo;
    logic [CW-1:0]                  r_rem;
    logic [CW-1:0]                  r_divisor;
    logic                           r_neg;
    logic [gsp_pkg::DIV_STEP_W-1:0] r_step;
    logic [CW-1:0]                  r_res_count;
    logic [PW-1:0]                  r_res_pos;

    // result register
    logic                   r_out_valid;
    logic signed [VW-1:0]   r_out_value;
    logic [CW-1:0]          r_out_count;
    logic [PW-1:0]          r_out_pos;
    logic                   r_out_fallback;

    logic signed [VW-1:0]   direct_value;
    logic [CW-1:0]          direct_count;
    logic                   direct_fallback;
    logic [VW-1:0]          kept_mag;
    logic [CW:0]            div_trial;
    logic                   div_ge;
    logic signed [VW-1:0]   div_value;
    logic                   keep;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_mode       <= gsp_pkg::MODE_SUM;
            r_score_threshold <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == gsp_pkg::CFG_POOL_MODE) begin
                r_pool_mode <= gsp_pkg::t_pool_mode'(i_cfg_wdata[1:0]);
            end else if (i_cfg_index == gsp_pkg::CFG_SCORE_THRESHOLD) begin
                r_score_threshold <= signed'(i_cfg_wdata[SW-1:0]);
            end
        end
    end

    // score update with saturating sums
    always_comb begin
        logic signed [VW:0] gsum;
        logic signed [VW:0] ksum;
        gsum = '0;
        ksum = '0;
        keep = (i_score >= r_score_threshold);

        gsum = {r_group_sum[VW-1], r_group_sum} + (VW+1)'(i_score);
        if (gsum > (VW+1)'(ACC_MAX)) begin
            n_group_sum = ACC_MAX;
        end else if (gsum < (VW+1)'(ACC_MIN)) begin
            n_group_sum = ACC_MIN;
        end else begin
            n_group_sum = gsum[VW-1:0];
        end

        n_kept_sum   = r_kept_sum;
        n_kept_tally = r_kept_tally;
        if (keep) begin
            ksum = {r_kept_sum[VW-1], r_kept_sum} + (VW+1)'(i_score);
            if (ksum > (VW+1)'(ACC_MAX)) begin
                n_kept_sum = ACC_MAX;
            end else if (ksum < (VW+1)'(ACC_MIN)) begin
                n_kept_sum = ACC_MIN;
            end else begin
                n_kept_sum = ksum[VW-1:0];
            end
            if (r_kept_tally != gsp_pkg::TALLY_MAX) begin
                n_kept_tally = r_kept_tally + CW'(1);
            end
        end

        // first score of a group always wins; ties keep the earlier one
        if (!r_group_open || (i_score > r_best_score)) begin
            n_best_score = i_score;
            n_best_pos   = r_col_pos;
        end else begin
            n_best_score = r_best_score;
            n_best_pos   = r_best_pos;
        end

        if (i_column_end || (r_col_pos == PW'(gsp_pkg::MAX_REGIONS - 1))) begin
            n_col_pos = '0;
        end else begin
            n_col_pos = r_col_pos + PW'(1);
        end
    end

    // result for modes that finish at once
    always_comb begin
        direct_value    = n_group_sum;
        direct_count    = '0;
        direct_fallback = 1'b0;
        unique case (r_pool_mode)
            gsp_pkg::MODE_SUM: begin
                direct_value = n_group_sum;
            end
            gsp_pkg::MODE_MAX: begin
                direct_value = VW'(n_best_score);
            end
            gsp_pkg::MODE_TSUM: begin
                direct_count = n_kept_tally;
                if (n_kept_tally == '0) begin
                    direct_value    = n_group_sum;
                    direct_fallback = 1'b1;
                end else begin
                    direct_value = n_kept_sum;
                end
            end
            gsp_pkg::MODE_TAVG: begin
                direct_count    = n_kept_tally;
                direct_value    = VW'(n_best_score);
                direct_fallback = 1'b1;
            end
            default: begin
                direct_value = n_group_sum;
            end
        endcase
    end

    assign kept_mag  = n_kept_sum[VW-1] ? VW'(-n_kept_sum) : VW'(n_kept_sum);
    assign div_trial = {r_rem, r_quo[VW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_divisor});
    assign div_value = r_neg ? -signed'(r_quo) : signed'(r_quo);

    // group state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_sum   <= '0;
            r_group_sum  <= '0;
            r_best_score <= BEST_INIT;
            r_best_pos   <= '0;
            r_kept_tally <= '0;
            r_col_pos    <= '0;
            r_group_open <= 1'b0;
        end else if (i_cmd.acc) begin
            r_col_pos <= n_col_pos;
            if (i_cmd.start_div || i_cmd.load_direct) begin
                r_kept_sum   <= '0;
                r_group_sum  <= '0;
                r_best_score <= BEST_INIT;
                r_best_pos   <= '0;
                r_kept_tally <= '0;
                r_group_open <= 1'b0;
            end else begin
                r_kept_sum   <= n_kept_sum;
                r_group_sum  <= n_group_sum;
                r_best_score <= n_best_score;
                r_best_pos   <= n_best_pos;
                r_kept_tally <= n_kept_tally;
                r_group_open <= 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.start_div) begin
            r_quo       <= kept_mag;
            r_rem       <= '0;
            r_divisor   <= n_kept_tally;
            r_neg       <= n_kept_sum[VW-1];
            r_step      <= '0;
            r_res_count <= n_kept_tally;
            r_res_pos   <= n_best_pos;
        end else if (i_cmd.div_step) begin
            r_rem  <= div_ge ? CW'(div_trial - {1'b0, r_divisor}) : CW'(div_trial);
            r_quo  <= {r_quo[VW-2:0], div_ge};
            r_step <= r_step + gsp_pkg::DIV_STEP_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_direct || i_cmd.load_div) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_direct) begin
            r_out_value    <= direct_value;
            r_out_count    <= direct_count;
            r_out_pos      <= n_best_pos;
            r_out_fallback <= direct_fallback;
        end else if (i_cmd.load_div) begin
            r_out_value    <= div_value;
            r_out_count    <= r_res_count;
            r_out_pos      <= r_res_pos;
            r_out_fallback <= 1'b0;
        end
    end

    // status back to controller
    assign o_status.need_div = (r_pool_mode == gsp_pkg::MODE_TAVG) && (n_kept_tally != '0);
    assign o_status.div_last = (r_step == gsp_pkg::DIV_STEP_W'(gsp_pkg::DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_pooled_value  = r_out_value;
    assign o_kept_count    = r_out_count;
    assign o_max_position  = r_out_pos;
    assign o_used_fallback = r_out_fallback;

endmodule

// ----- design/grouped_score_pooling.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_score_pooling
// Pools a stream of Q8.8 region scores per group: sum, max, thresholded sum
// or thresholded average, with kept count and position of the maximum.
// ----------------------------------------------------------------------------
// Throughput: one score per cycle while the result register is not blocked and
//   groups close in sum, max or thresholded-sum mode, or in average mode with nothing kept.
// Results that need no division show in the cycle after their group-end transaction.
// Thresholded average with kept scores: the shared restoring divider works out the
//   quotient one bit per step, then loads it once the result register is free; input is stalled meanwhile.
// Reset (synchronous, active low) clears configuration, group state,
//   column position and the result valid flag; no clearing pass.
module grouped_score_pooling (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [gsp_pkg::SCORE_W-1:0]    i_score,
    input  logic                                  i_group_end,
    input  logic                                  i_column_end,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [gsp_pkg::VALUE_W-1:0]    o_pooled_value,
    output logic [gsp_pkg::COUNT_W-1:0]           o_kept_count,
    output logic [gsp_pkg::POS_W-1:0]             o_max_position,
    output logic                                  o_used_fallback
);

    gsp_pkg::t_dp_cmd    cmd;
    gsp_pkg::t_dp_status status;

    // controller
    gsp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_group_end   (i_group_end),
        .i_out_stall   (i_out_stall),
        .i_out_valid_q (o_out_valid),
        .i_status      (status),
        .o_in_stall    (o_in_stall),
        .o_cmd         (cmd)
    );

    // datapath
    gsp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_score         (i_score),
        .i_column_end    (i_column_end),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_pooled_value  (o_pooled_value),
        .o_kept_count    (o_kept_count),
        .o_max_position  (o_max_position),
        .o_used_fallback (o_used_fallback)
    );

endmodule

// ----- design/gsp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks for the grouped score pooling block.
// ----------------------------------------------------------------------------
module gsp_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  i_group_end,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [gsp_pkg::VALUE_W-1:0]    o_pooled_value,
    input logic [gsp_pkg::COUNT_W-1:0]           o_kept_count,
    input logic                                  o_used_fallback
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a score that does not end a group makes no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_group_end && !o_out_valid) |=> !o_out_valid)
        else $error("result without group end");

    // fallback means nothing was kept
    a_fallback_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_used_fallback) |-> (o_kept_count == '0))
        else $error("fallback with nonzero kept count");

    // a group end never overruns a blocked result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && i_group_end) |-> o_in_stall)
        else $error("group end accepted while result blocked");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pooled_value)))
        else $error("stalled result changed");

endmodule

bind grouped_score_pooling gsp_checker u_gsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_group_end     (i_group_end),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pooled_value  (o_pooled_value),
    .o_kept_count    (o_kept_count),
    .o_used_fallback (o_used_fallback)
);

// ----- bench/grouped_score_pooling_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_score_pooling_test
// Self-checking bench for the grouped score pooling block. A local model of
// the pooling rules predicts each group result from the accepted score
// transactions; the output side checks every result transaction against it.
// Covers reset defaults, all modes, threshold extremes, both fallbacks,
// truncation of negative averages, ignored register indexes and random
// grouped streams with random bursts of idling on both sides.
// ----------------------------------------------------------------------------
module grouped_score_pooling_test;

    localparam int CLK_HALF       = 5;
    // divider run plus load, with margin, for the pause before register writes
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int CALM_ITEMS     = 50;
    localparam int PHASE_ITEMS    = 60;

    localparam longint ACC_HI = (longint'(1) <<< (gsp_pkg::VALUE_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (gsp_pkg::VALUE_W - 1));

    localparam logic signed [gsp_pkg::SCORE_W-1:0] SCORE_HI =
        {1'b0, {(gsp_pkg::SCORE_W-1){1'b1}}};
    localparam logic signed [gsp_pkg::SCORE_W-1:0] SCORE_LO =
        {1'b1, {(gsp_pkg::SCORE_W-1){1'b0}}};

    // indexes past the two registers, writes there must do nothing
    localparam logic [gsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = gsp_pkg::CFG_IDX_W'(2);
    localparam logic [gsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = gsp_pkg::CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [gsp_pkg::VALUE_W-1:0] value;
        logic [gsp_pkg::COUNT_W-1:0]        count;
        logic [gsp_pkg::POS_W-1:0]          position;
        logic                               fallback;
    } t_pooled_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [gsp_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [gsp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [gsp_pkg::SCORE_W-1:0] i_score;
    logic                               i_group_end;
    logic                               i_column_end;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [gsp_pkg::VALUE_W-1:0] o_pooled_value;
    logic [gsp_pkg::COUNT_W-1:0]        o_kept_count;
    logic [gsp_pkg::POS_W-1:0]          o_max_position;
    logic                               o_used_fallback;

    // model copy of configuration and group state
    gsp_pkg::t_pool_mode                mode_reg;
    logic signed [gsp_pkg::SCORE_W-1:0] threshold_reg;
    longint                             kept_total;
    longint                             group_total;
    logic signed [gsp_pkg::SCORE_W-1:0] peak_score;
    logic [gsp_pkg::POS_W-1:0]          peak_pos;
    int unsigned                        kept_n;
    logic [gsp_pkg::POS_W-1:0]          column_pos;
    bit                                 group_open;

    t_pooled_result expected_pool[$];
    int             error_count  = 0;
    bit             idle_enable  = 1'b1;
    bit             input_held   = 1'b0;
    int             quiet_cycles = 0;

    grouped_score_pooling u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_score         (i_score),
        .i_group_end     (i_group_end),
        .i_column_end    (i_column_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pooled_value  (o_pooled_value),
        .o_kept_count    (o_kept_count),
        .o_max_position  (o_max_position),
        .o_used_fallback (o_used_fallback)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // pooling model
    // ------------------------------------------------------------------------

    function automatic longint clamp_acc(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic void clear_group_state();
        kept_total  = 0;
        group_total = 0;
        peak_score  = SCORE_LO;
        peak_pos    = '0;
        kept_n      = 0;
        group_open  = 1'b0;
    endfunction

    function automatic void reset_pool_model();
        mode_reg      = gsp_pkg::MODE_SUM;
        threshold_reg = '0;
        column_pos    = '0;
        clear_group_state();
    endfunction

    // take one accepted score; queue the group result on group end
    function automatic void pool_score(logic signed [gsp_pkg::SCORE_W-1:0] s, logic gend,
                                       logic cend);
        t_pooled_result res;
        longint         pooled;
        group_total = clamp_acc(group_total + longint'(s));
        // first score of a group always becomes the max; ties keep the earlier one
        if (!group_open || s > peak_score) begin
            peak_score = s;
            peak_pos   = column_pos;
        end
        group_open = 1'b1;
        if (s >= threshold_reg) begin
            kept_total = clamp_acc(kept_total + longint'(s));
            if (kept_n < gsp_pkg::TALLY_MAX)
                kept_n++;
        end
        if (cend || column_pos == gsp_pkg::POS_W'(gsp_pkg::MAX_REGIONS - 1))
            column_pos = '0;
        else
            column_pos = column_pos + 1'b1;
        if (!gend)
            return;
        res.count    = '0;
        res.fallback = 1'b0;
        case (mode_reg)
            gsp_pkg::MODE_SUM: pooled = group_total;
            gsp_pkg::MODE_MAX: pooled = longint'(peak_score);
            gsp_pkg::MODE_TSUM: begin
                res.count = gsp_pkg::COUNT_W'(kept_n);
                if (kept_n == 0) begin
                    pooled       = group_total;
                    res.fallback = 1'b1;
                end else begin
                    pooled = kept_total;
                end
            end
            default: begin
                res.count = gsp_pkg::COUNT_W'(kept_n);
                if (kept_n == 0) begin
                    pooled       = longint'(peak_score);
                    res.fallback = 1'b1;
                end else begin
                    // longint division truncates toward zero
                    pooled = kept_total / longint'(kept_n);
                end
            end
        endcase
        res.value    = pooled[gsp_pkg::VALUE_W-1:0];
        res.position = peak_pos;
        expected_pool.push_back(res);
        clear_group_state();
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    task automatic write_register(logic [gsp_pkg::CFG_IDX_W-1:0] idx,
                                  logic [gsp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            gsp_pkg::CFG_POOL_MODE:       mode_reg = gsp_pkg::t_pool_mode'(data[1:0]);
            gsp_pkg::CFG_SCORE_THRESHOLD: threshold_reg = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one score transaction; valid stays high afterwards until released
    task automatic send_score(logic signed [gsp_pkg::SCORE_W-1:0] s, logic gend, logic cend);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            if (input_held)
                i_in_valid <= 1'b0;
            input_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_score      <= s;
        i_group_end  <= gend;
        i_column_end <= cend;
        input_held = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pool_score(s, gend, cend);
    endtask

    // drop valid, wait for every pending result, then let the block settle
    task automatic wait_for_results();
        if (input_held)
            i_in_valid <= 1'b0;
        input_held = 1'b0;
        while (expected_pool.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pooling(gsp_pkg::t_pool_mode md,
                               logic signed [gsp_pkg::SCORE_W-1:0] thr);
        wait_for_results();
        write_register(gsp_pkg::CFG_POOL_MODE, gsp_pkg::CFG_DATA_W'(md));
        write_register(gsp_pkg::CFG_SCORE_THRESHOLD, thr);
    endtask

    function automatic logic signed [gsp_pkg::SCORE_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return SCORE_LO;
            1:       return SCORE_HI;
            2:       return '0;
            3:       return gsp_pkg::SCORE_W'($urandom);
            default: return gsp_pkg::SCORE_W'(longint'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    // mix of extremes, values around the threshold and full-range noise
    function automatic logic signed [gsp_pkg::SCORE_W-1:0] pick_score(
        logic signed [gsp_pkg::SCORE_W-1:0] thr);
        longint near;
        case ($urandom_range(0, 9))
            0: return SCORE_HI;
            1: return SCORE_LO;
            2, 3: begin
                near = longint'(thr) + longint'($urandom_range(0, 8)) - 4;
                if (near > longint'(SCORE_HI)) near = longint'(SCORE_HI);
                if (near < longint'(SCORE_LO)) near = longint'(SCORE_LO);
                return near[gsp_pkg::SCORE_W-1:0];
            end
            default: return gsp_pkg::SCORE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // output side: random stall bursts
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pooled_result got;
        t_pooled_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_pooled_value, o_kept_count, o_max_position, o_used_fallback};
            if (expected_pool.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction, value %0d count %0d pos %0d fb %0b",
                         $time, $signed(got.value), got.count, got.position, got.fallback);
            end else begin
                want = expected_pool.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: result mismatch, expected value %0d count %0d pos %0d fb %0b",
                             $time, $signed(want.value), want.count, want.position,
                             want.fallback);
                    $display("%0t:                  actual value %0d count %0d pos %0d fb %0b",
                             $time, $signed(got.value), got.count, got.position, got.fallback);
                end
            end
        end
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results pending",
                         $time, quiet_cycles, expected_pool.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // configuration after reset is sum mode with threshold zero
    task automatic test_reset_config();
        send_score(16'sd100, 1'b0, 1'b0);
        send_score(-16'sd50, 1'b1, 1'b0);
    endtask

    // each mode on extreme scores, a tie on the max and a column end mid-group
    task automatic test_mode_sweep();
        gsp_pkg::t_pool_mode md;
        md = md.first();
        do begin
            set_pooling(md, '0);
            send_score(SCORE_LO, 1'b0, 1'b0);
            send_score(SCORE_HI, 1'b0, 1'b1);
            send_score(SCORE_HI, 1'b1, 1'b0);
            md = md.next();
        end while (md != md.first());
    endtask

    // nothing reaches the top threshold: group sum, then group max
    task automatic test_fallbacks();
        set_pooling(gsp_pkg::MODE_TSUM, SCORE_HI);
        send_score(-16'sd5, 1'b0, 1'b0);
        send_score(16'sd100, 1'b1, 1'b0);
        set_pooling(gsp_pkg::MODE_TAVG, SCORE_HI);
        send_score(-16'sd5, 1'b0, 1'b0);
        send_score(-16'sd2, 1'b1, 1'b0);
    endtask

    // averages of odd sums truncate toward zero on both signs
    task automatic test_average_truncation();
        set_pooling(gsp_pkg::MODE_TAVG, SCORE_LO);
        send_score(-16'sd3, 1'b0, 1'b0);
        send_score(-16'sd4, 1'b1, 1'b0);
        send_score(16'sd3, 1'b0, 1'b0);
        send_score(16'sd4, 1'b1, 1'b0);
    endtask

    // writes past the last register leave the configuration alone
    task automatic test_spare_indexes();
        wait_for_results();
        write_register(CFG_SPARE_2, gsp_pkg::CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_3, gsp_pkg::CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_2, ~gsp_pkg::CFG_DATA_W'($urandom));
        send_score(16'sd7, 1'b0, 1'b0);
        send_score(-16'sd9, 1'b1, 1'b0);
    endtask

    // random groups in phases of random configuration
    task automatic test_random_streams(int unsigned n_items);
        int unsigned                        sent;
        int unsigned                        phase_sent;
        int unsigned                        len;
        logic signed [gsp_pkg::SCORE_W-1:0] thr;
        sent = 0;
        while (sent < n_items) begin
            thr = pick_threshold();
            set_pooling(gsp_pkg::t_pool_mode'($urandom_range(gsp_pkg::MODE_SUM,
                                                             gsp_pkg::MODE_TAVG)), thr);
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_score(pick_score(thr), k == len - 1, $urandom_range(0, 9) == 0);
                phase_sent += len;
                // hold off the sender until the output side has caught up
                if (idle_enable && $urandom_range(0, 9) == 0)
                    wait_for_results();
            end
            sent += phase_sent;
        end
    endtask

    // last part with no idling on either side
    task automatic test_full_rate();
        wait_for_results();
        idle_enable = 1'b0;
        test_random_streams(CALM_ITEMS);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_wdata  <= '0;
        i_in_valid   <= 1'b0;
        i_score      <= '0;
        i_group_end  <= 1'b0;
        i_column_end <= 1'b0;
        reset_pool_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_mode_sweep();
        test_fallbacks();
        test_average_truncation();
        test_spare_indexes();
        test_random_streams(RANDOM_ITEMS);
        test_full_rate();

        wait_for_results();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
